### design/gmb_pkg.sv
// Shared types, constants and helpers for the grid maze backtracker.
package gmb_pkg;

    // Default store size, handed to the top-level parameters.
    localparam int DEF_MAX_COLUMNS = 32;
    localparam int DEF_MAX_ROWS    = 32;

    // Stream payload widths (bytes-rounded).
    localparam int IN_W  = 24;
    localparam int OUT_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 6;
    localparam logic [CFG_IDX_W-1:0] REG_MAZE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAZE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET   = 6'd32;

    // Width used for dimension compares; holds up to 511.
    localparam int DIM_W = 9;

    // Cell word: {seen, walls[3:0]}.
    localparam int CELL_W   = 5;
    localparam int SEEN_BIT = 4;
    localparam logic [3:0] WALL_N    = 4'b0001;
    localparam logic [3:0] WALL_S    = 4'b0010;
    localparam logic [3:0] WALL_E    = 4'b0100;
    localparam logic [3:0] WALL_W    = 4'b1000;
    localparam logic [3:0] WALLS_ALL = 4'b1111;

    // Probe sequence: current cell, then N, S, E, W.
    localparam logic [2:0] PROBE_LAST = 3'd4;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STEP  = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        DIR_N = 2'd0,
        DIR_S = 2'd1,
        DIR_E = 2'd2,
        DIR_W = 2'd3
    } t_dir;

    typedef enum logic [3:0] {
        ST_BOOT_CLR,
        ST_IDLE,
        ST_START_CLR,
        ST_INIT,
        ST_PROBE,
        ST_SETTLE,
        ST_CHOOSE,
        ST_WR_CUR,
        ST_WR_NB,
        ST_POP,
        ST_POP_WAIT,
        ST_OUT_RD,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load_item;
        logic clr_write;
        logic init;
        logic probe;
        logic choose;
        logic wr_cur;
        logic wr_nb;
        logic pop;
        logic pop_load;
        logic out_rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic probe_last;
        logic has_nb;
        logic stack_empty;
        logic out_free;
    } t_sts;

    // Wall removed on the current cell when moving in direction d.
    function automatic logic [3:0] here_wall(input t_dir d);
        logic [3:0] m;
        unique case (d)
            DIR_N:   m = WALL_N;
            DIR_S:   m = WALL_S;
            DIR_E:   m = WALL_E;
            DIR_W:   m = WALL_W;
            default: m = WALL_N;
        endcase
        return m;
    endfunction

    // Wall removed on the neighbor entered in direction d.
    function automatic logic [3:0] there_wall(input t_dir d);
        logic [3:0] m;
        unique case (d)
            DIR_N:   m = WALL_S;
            DIR_S:   m = WALL_N;
            DIR_E:   m = WALL_W;
            DIR_W:   m = WALL_E;
            default: m = WALL_S;
        endcase
        return m;
    endfunction

endpackage

### design/gmb_ctrl.sv
// Sequencer for the maze backtracker: decodes beats and steps the datapath.
module gmb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  gmb_pkg::t_opcode i_opcode,
    output logic             o_in_ready,
    input  gmb_pkg::t_sts    i_sts,
    output gmb_pkg::t_cmd    o_cmd
);
    import gmb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BOOT_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_BOOT_CLR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_opcode)
                        OP_START: n_state = ST_START_CLR;
                        OP_STEP:  n_state = i_sts.stack_empty ? ST_OUT_RD : ST_PROBE;
                        default:  n_state = ST_OUT_RD;
                    endcase
                end
            end
            ST_START_CLR: begin
                if (i_sts.clr_last) n_state = ST_INIT;
            end
            ST_INIT:     n_state = ST_OUT_RD;
            ST_PROBE: begin
                if (i_sts.probe_last) n_state = ST_SETTLE;
            end
            ST_SETTLE:   n_state = ST_CHOOSE;
            ST_CHOOSE:   n_state = i_sts.has_nb ? ST_WR_CUR : ST_POP;
            ST_WR_CUR:   n_state = ST_WR_NB;
            ST_WR_NB:    n_state = ST_OUT_RD;
            ST_POP:      n_state = ST_POP_WAIT;
            ST_POP_WAIT: n_state = ST_OUT_RD;
            ST_OUT_RD:   n_state = ST_RESP;
            ST_RESP: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default:     n_state = ST_BOOT_CLR;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_BOOT_CLR:  o_cmd.clr_write = 1'b1;
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            ST_START_CLR: o_cmd.clr_write = 1'b1;
            ST_INIT:      o_cmd.init      = 1'b1;
            ST_PROBE:     o_cmd.probe     = 1'b1;
            ST_SETTLE:    o_cmd           = '0;
            ST_CHOOSE:    o_cmd.choose    = 1'b1;
            ST_WR_CUR:    o_cmd.wr_cur    = 1'b1;
            ST_WR_NB:     o_cmd.wr_nb     = 1'b1;
            ST_POP:       o_cmd.pop       = 1'b1;
            ST_POP_WAIT:  o_cmd.pop_load  = 1'b1;
            ST_OUT_RD:    o_cmd.out_rd    = 1'b1;
            ST_RESP:      o_cmd.out_load  = i_sts.out_free;
            default:      o_cmd           = '0;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != ST_IDLE))
        else $error("accepted beat did not start work");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over a pending one");

    a_choose_after_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHOOSE) |-> ($past(r_state) == ST_SETTLE))
        else $error("choice made before probes settled");

endmodule

### design/gmb_datapath.sv
// Maze datapath: cell store, path stack, probe capture, neighbor choice, result reg.
module gmb_datapath #(
    parameter int MAX_COLUMNS = gmb_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = gmb_pkg::DEF_MAX_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gmb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gmb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [gmb_pkg::IN_W-1:0]      i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [gmb_pkg::OUT_W-1:0]     o_out_data,
    input  gmb_pkg::t_cmd                 i_cmd,
    output gmb_pkg::t_sts                 o_sts
);
    import gmb_pkg::*;

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int XW    = $clog2(MAX_COLUMNS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int EW    = XW + YW;

    // Stores
    logic [CELL_W-1:0] r_cell_mem  [CELLS];
    logic [EW-1:0]     r_stack_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;
    logic [EW-1:0]     r_stk_rd;

    // Control state
    logic [CFG_W-1:0] r_cfg_w, r_cfg_h;
    logic [CW-1:0]    r_cnt;
    logic             r_done;
    logic [AW-1:0]    r_clr_addr;
    logic [2:0]       r_probe;
    logic             r_cap_vld;
    logic             r_out_valid;

    // Payload
    logic [7:0]        r_rnd;
    logic [4:0]        r_col, r_row;
    logic [XW-1:0]     r_top_x;
    logic [YW-1:0]     r_top_y;
    logic [2:0]        r_cap_idx;
    logic [CELL_W-1:0] r_cur_data;
    logic [3:0]        r_avail;
    logic [3:0]        r_nb_walls [4];
    t_dir              r_dir;
    logic [OUT_W-1:0]  r_out_data;

    // Effective dimensions
    logic [DIM_W-1:0] w_eff, h_eff;
    always_comb begin
        if (r_cfg_w == '0)                              w_eff = DIM_W'(1);
        else if (DIM_W'(r_cfg_w) > DIM_W'(MAX_COLUMNS)) w_eff = DIM_W'(MAX_COLUMNS);
        else                                            w_eff = DIM_W'(r_cfg_w);
        if (r_cfg_h == '0)                              h_eff = DIM_W'(1);
        else if (DIM_W'(r_cfg_h) > DIM_W'(MAX_ROWS))    h_eff = DIM_W'(MAX_ROWS);
        else                                            h_eff = DIM_W'(r_cfg_h);
    end

    // Neighbors of the top cell; out-of-grid ones fall back to the top cell
    logic [XW-1:0] nb_x [4];
    logic [YW-1:0] nb_y [4];
    logic [3:0]    nb_in;
    always_comb begin
        nb_in[DIR_N] = (r_top_y != '0);
        nb_in[DIR_S] = (DIM_W'(r_top_y) + DIM_W'(1)) < h_eff;
        nb_in[DIR_E] = (DIM_W'(r_top_x) + DIM_W'(1)) < w_eff;
        nb_in[DIR_W] = (r_top_x != '0);
        for (int d = 0; d < 4; d++) begin
            nb_x[d] = r_top_x;
            nb_y[d] = r_top_y;
        end
        if (nb_in[DIR_N]) nb_y[DIR_N] = r_top_y - YW'(1);
        if (nb_in[DIR_S]) nb_y[DIR_S] = r_top_y + YW'(1);
        if (nb_in[DIR_E]) nb_x[DIR_E] = r_top_x + XW'(1);
        if (nb_in[DIR_W]) nb_x[DIR_W] = r_top_x - XW'(1);
    end

    // Neighbor choice: entry (rnd * count) >> 8 among open neighbors
    logic [2:0]  nb_cnt;
    logic [10:0] pick_prod;
    logic [2:0]  pick_k;
    t_dir        sel_dir;
    assign nb_cnt    = 3'($countones(r_avail));
    assign pick_prod = {3'b000, r_rnd} * {8'h00, nb_cnt};
    assign pick_k    = pick_prod[10:8];

    always_comb begin
        logic [2:0] seen_cnt;
        seen_cnt = '0;
        sel_dir  = DIR_N;
        for (int d = 0; d < 4; d++) begin
            if (r_avail[d]) begin
                if (seen_cnt == pick_k) sel_dir = t_dir'(2'(d));
                seen_cnt = seen_cnt + 3'd1;
            end
        end
    end

    // Cell address mux
    logic [1:0]        probe_dir;
    logic              in_store;
    logic [XW-1:0]     a_x;
    logic [YW-1:0]     a_y;
    logic [AW-1:0]     cell_addr, mem_addr;
    logic              mem_we, mem_re;
    logic [CELL_W-1:0] mem_wdata;

    assign probe_dir = 2'(r_probe - 3'd1);
    assign in_store  = (DIM_W'(r_col) < DIM_W'(MAX_COLUMNS)) &&
                       (DIM_W'(r_row) < DIM_W'(MAX_ROWS));

    always_comb begin
        a_x = '0;
        a_y = '0;
        if (i_cmd.probe) begin
            if (r_probe == '0) begin
                a_x = r_top_x;
                a_y = r_top_y;
            end else begin
                a_x = nb_x[probe_dir];
                a_y = nb_y[probe_dir];
            end
        end else if (i_cmd.wr_nb) begin
            a_x = nb_x[r_dir];
            a_y = nb_y[r_dir];
        end else if (i_cmd.out_rd) begin
            if (in_store) begin
                a_x = XW'(r_col);
                a_y = YW'(r_row);
            end
        end else if (i_cmd.wr_cur) begin
            a_x = r_top_x;
            a_y = r_top_y;
        end
    end

    assign cell_addr = AW'(a_y) * AW'(MAX_COLUMNS) + AW'(a_x);
    assign mem_addr  = i_cmd.clr_write ? r_clr_addr : cell_addr;
    assign mem_re    = i_cmd.probe | i_cmd.out_rd;
    assign mem_we    = i_cmd.clr_write | i_cmd.init | i_cmd.wr_cur | i_cmd.wr_nb |
                       (i_cmd.pop && (r_cnt == CW'(1)));

    always_comb begin
        if (i_cmd.clr_write)   mem_wdata = {1'b0, WALLS_ALL};
        else if (i_cmd.init)   mem_wdata = {1'b1, WALLS_ALL};
        else if (i_cmd.wr_cur) mem_wdata = {r_cur_data[SEEN_BIT],
                                            r_cur_data[3:0] & ~here_wall(r_dir)};
        else if (i_cmd.wr_nb)  mem_wdata = {1'b1, r_nb_walls[r_dir] & ~there_wall(r_dir)};
        else                   mem_wdata = {1'b1, r_cur_data[3:0] & ~WALL_N};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_cell_mem[mem_addr] <= mem_wdata;
        if (mem_re) r_rd_data <= r_cell_mem[mem_addr];
    end

    // Path stack
    logic          push_ok;
    logic          stk_we;
    logic [AW-1:0] stk_waddr;
    logic [EW-1:0] stk_wdata;
    logic [CW-1:0] pop_idx;

    assign push_ok   = r_cnt < CW'(CELLS);
    assign stk_we    = i_cmd.init | (i_cmd.wr_nb & push_ok);
    assign stk_waddr = i_cmd.init ? '0 : r_cnt[AW-1:0];
    assign stk_wdata = i_cmd.init ? '0 : {nb_y[r_dir], nb_x[r_dir]};
    assign pop_idx   = r_cnt - CW'(2);

    always_ff @(posedge i_clk) begin
        if (stk_we)    r_stack_mem[stk_waddr] <= stk_wdata;
        if (i_cmd.pop) r_stk_rd <= r_stack_mem[pop_idx[AW-1:0]];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= CFG_DIM_RESET;
            r_cfg_h     <= CFG_DIM_RESET;
            r_cnt       <= '0;
            r_done      <= 1'b0;
            r_clr_addr  <= '0;
            r_probe     <= '0;
            r_cap_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MAZE_WIDTH:  r_cfg_w <= i_cfg_data;
                    REG_MAZE_HEIGHT: r_cfg_h <= i_cfg_data;
                    default:         r_cfg_w <= r_cfg_w;
                endcase
            end
            if (i_cmd.clr_write) begin
                r_clr_addr <= o_sts.clr_last ? '0 : r_clr_addr + AW'(1);
            end
            if (i_cmd.init) begin
                r_cnt  <= CW'(1);
                r_done <= 1'b0;
            end else if (i_cmd.wr_nb && push_ok) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.pop) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) r_done <= 1'b1;
            end
            if (i_cmd.load_item)  r_probe <= '0;
            else if (i_cmd.probe) r_probe <= r_probe + 3'd1;
            r_cap_vld <= i_cmd.probe;
            if (i_cmd.out_load)   r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_rnd <= i_in_data[9:2];
            r_col <= i_in_data[14:10];
            r_row <= i_in_data[19:15];
        end
        r_cap_idx <= r_probe;
        if (r_cap_vld) begin
            if (r_cap_idx == '0) begin
                r_cur_data <= r_rd_data;
            end else begin
                r_avail[2'(r_cap_idx - 3'd1)]    <= nb_in[2'(r_cap_idx - 3'd1)] &
                                                    ~r_rd_data[SEEN_BIT];
                r_nb_walls[2'(r_cap_idx - 3'd1)] <= r_rd_data[3:0];
            end
        end
        if (i_cmd.choose) r_dir <= sel_dir;
        if (i_cmd.init) begin
            r_top_x <= '0;
            r_top_y <= '0;
        end else if (i_cmd.wr_nb && push_ok) begin
            r_top_x <= nb_x[r_dir];
            r_top_y <= nb_y[r_dir];
        end else if (i_cmd.pop_load && (r_cnt != '0)) begin
            r_top_x <= r_stk_rd[XW-1:0];
            r_top_y <= r_stk_rd[EW-1:XW];
        end
        if (i_cmd.out_load) begin
            r_out_data <= {(r_cnt != '0) ? 5'(r_top_y) : 5'd0,
                           (r_cnt != '0) ? 5'(r_top_x) : 5'd0,
                           r_done,
                           in_store & r_rd_data[SEEN_BIT],
                           in_store ? r_rd_data[3:0] : 4'd0};
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_sts.clr_last    = (r_clr_addr == AW'(CELLS - 1));
    assign o_sts.probe_last  = (r_probe == PROBE_LAST);
    assign o_sts.has_nb      = (nb_cnt != '0);
    assign o_sts.stack_empty = (r_cnt == '0);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    a_done_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_cnt == '0))
        else $error("done set with cells still on the stack");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CELLS))
        else $error("stack count past capacity");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

### design/grid_maze_backtracker_top.sv
// Top level of the grid maze backtracker: stream ports, config port, ctrl + datapath.
//
// Usage:
//   Input beats on s_axis_* carry one command: start (clear grid, push cell 0,0),
//   step (one depth-first move or backtrack), read, or no-op. Every command
//   returns exactly one result beat on m_axis_* with the addressed cell's walls
//   and visited flag, the done flag and the cell now on top of the path stack.
//   Config writes (maze width / height) go through i_cfg_*; always ready, and
//   only to be issued while no command is in flight.
//   Sequence, from input accept to result valid:
//     read / no-op / step on empty stack : cell-store read, then result load
//     step                               : 5 serial cell-store reads, settle,
//                                          choice, 2 writes or a pop, result read
//     start                              : the one-cell-a-cycle clear of all
//                                          MAX_COLUMNS*MAX_ROWS cells, then init
//   A new command is taken once the previous result is loaded into the output
//   register, even if the receiver has not taken it yet.
//   Reset: the cell store is cleared one cell per cycle, all MAX_COLUMNS*MAX_ROWS
//   cells, with s_axis_tready low; config writes still land.
//   Receiver stall: the finished result sits in the output register; the block
//   holds its last step until that register frees.
module grid_maze_backtracker_top #(
    parameter int MAX_COLUMNS = gmb_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = gmb_pkg::DEF_MAX_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Config write channel: index 0 maze_width, index 1 maze_height
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gmb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gmb_pkg::CFG_W-1:0]     i_cfg_data,
    // Command beats
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] opcode, [9:2] random_byte, [14:10] cell_column, [19:15] cell_row,
    // [23:20] zero
    input  logic [gmb_pkg::IN_W-1:0]      s_axis_tdata,
    // Result beats
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [3:0] wall_bits, [4] cell_visited, [5] finished, [10:6] top_column,
    // [15:11] top_row
    output logic [gmb_pkg::OUT_W-1:0]     m_axis_tdata
);
    import gmb_pkg::*;

    // Command and status buses between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // Sequencer: one command at a time, walks the clear / probe / update steps
    gmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (t_opcode'(s_axis_tdata[1:0])),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: cell store, path stack, neighbor pick, config and result registers
    gmb_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
